>>> hdl/lcs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lcs_pkg
// Types, constants and the control store of the character LCD command
// sequencer.
// ============================================================================

package lcs_pkg;

    localparam int ADDR_W = 3;
    localparam int UPC_W  = 4;
    localparam int DIGITS = 10;
    localparam int Q_SHIFT = 35;
    localparam int Q_W     = 64 - Q_SHIFT;

    localparam logic [0:0]  REG_POWER_UP_WAIT = 1'b0;
    localparam logic [7:0]  POWER_UP_WAIT_RESET = 8'd8;

    localparam logic [2:0]  OP_TICK         = 3'd0;
    localparam logic [2:0]  OP_LOAD_CHAR    = 3'd1;
    localparam logic [2:0]  OP_CLEAR        = 3'd2;
    localparam logic [2:0]  OP_GOTO_XY      = 3'd3;
    localparam logic [2:0]  OP_SET_CURSOR   = 3'd4;
    localparam logic [2:0]  OP_PRINT_NUMBER = 3'd5;

    localparam logic [1:0]  LINE_ONE = 2'd0;
    localparam logic [1:0]  LINE_TWO = 2'd1;

    localparam logic [7:0]  CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0]  CMD_CLEAR        = 8'h01;
    localparam logic [7:0]  CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0]  LINE_TWO_OFFSET  = 8'h40;
    localparam logic [7:0]  ASCII_ZERO       = 8'd48;
    localparam logic [31:0] RECIP_10         = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_BUSY     = 2'd1,
        ST_TICK     = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_WAIT   = 5'b00001,
        PH_FUNC   = 5'b00010,
        PH_DISP   = 5'b00100,
        PH_CLR    = 5'b01000,
        PH_FINISH = 5'b10000
    } init_phase_t;

    typedef enum logic [4:0] {
        PR_IDLE   = 5'b00001,
        PR_WRITE  = 5'b00010,
        PR_CLEAR  = 5'b00100,
        PR_MOVE   = 5'b01000,
        PR_CURSOR = 5'b10000
    } proc_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  char_code;
        logic        last_char;
        logic [5:0]  x_pos;
        logic [1:0]  line_select;
        logic        cursor_on;
        logic        blink_on;
        logic [31:0] number;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       lcd_rs;
        logic       lcd_rw;
        logic       lcd_en;
        logic [7:0] lcd_data;
        logic       init_done;
        logic       idle;
    } rsp_t;

    typedef enum logic [3:0] {
        U_NOP      = 4'd0,
        U_LATCH    = 4'd1,
        U_STATUS   = 4'd2,
        U_EXEC     = 4'd3,
        U_WR_CHAR  = 4'd4,
        U_NUM_INIT = 4'd5,
        U_MUL      = 4'd6,
        U_DIGIT    = 4'd7,
        U_COPY     = 4'd8,
        U_NUM_DONE = 4'd9,
        U_EMIT     = 4'd10
    } uop_t;

    typedef enum logic [2:0] {
        J_ALWAYS   = 3'd0,
        J_ACCEPT   = 3'd1,
        J_DECODE   = 3'd2,
        J_QNZ      = 3'd3,
        J_MORE     = 3'd4,
        J_OUT_FREE = 3'd5
    } jmp_t;

    typedef struct packed {
        uop_t             uop;
        jmp_t             jmp;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    localparam logic [UPC_W-1:0] UPC_FETCH    = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DECODE   = 4'd1;
    localparam logic [UPC_W-1:0] UPC_EXEC     = 4'd2;
    localparam logic [UPC_W-1:0] UPC_READ     = 4'd3;
    localparam logic [UPC_W-1:0] UPC_WR_CHAR  = 4'd4;
    localparam logic [UPC_W-1:0] UPC_NUM_INIT = 4'd5;
    localparam logic [UPC_W-1:0] UPC_MUL      = 4'd6;
    localparam logic [UPC_W-1:0] UPC_DIGIT    = 4'd7;
    localparam logic [UPC_W-1:0] UPC_COPY     = 4'd8;
    localparam logic [UPC_W-1:0] UPC_NUM_DONE = 4'd9;
    localparam logic [UPC_W-1:0] UPC_EMIT     = 4'd10;

    // The conditional steps fall through to the next address when not taken,
    // except the two wait steps, which hold.
    function automatic ctrl_t lcs_ucode(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{U_NOP, J_ALWAYS, UPC_FETCH};
        case (addr)
            UPC_FETCH:    w = '{U_LATCH,    J_ACCEPT,   UPC_DECODE};
            UPC_DECODE:   w = '{U_STATUS,   J_DECODE,   UPC_EXEC};
            UPC_EXEC:     w = '{U_EXEC,     J_ALWAYS,   UPC_EMIT};
            UPC_READ:     w = '{U_NOP,      J_ALWAYS,   UPC_WR_CHAR};
            UPC_WR_CHAR:  w = '{U_WR_CHAR,  J_ALWAYS,   UPC_EMIT};
            UPC_NUM_INIT: w = '{U_NUM_INIT, J_ALWAYS,   UPC_MUL};
            UPC_MUL:      w = '{U_MUL,      J_ALWAYS,   UPC_DIGIT};
            UPC_DIGIT:    w = '{U_DIGIT,    J_QNZ,      UPC_MUL};
            UPC_COPY:     w = '{U_COPY,     J_MORE,     UPC_COPY};
            UPC_NUM_DONE: w = '{U_NUM_DONE, J_ALWAYS,   UPC_EMIT};
            UPC_EMIT:     w = '{U_EMIT,     J_OUT_FREE, UPC_FETCH};
            default:      w = '{U_NOP,      J_ALWAYS,   UPC_FETCH};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/char_lcd_command_sequencer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// char_lcd_command_sequencer_top
// Microcoded sequencer for an 8-bit character LCD: power-up commands, buffered
// character writes, decimal number printing and clear, cursor and address commands.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  lcs_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall  lcs_pkg::rsp_t
//   apb      in         psel / penable         power_up_wait at address 0
//
// A tick or request steps through fetch, decode, execute and emit; a tick
// that drives a buffered character steps through read and write-character
// in place of execute, for the registered read of the character buffer.
// Print number runs number init, a reciprocal multiply and a remainder step
// per digit, one copy per digit on the single buffer write port, number done and emit.
// After reset the block takes items at once; there is no clearing pass.
// A stalled result holds the sequencer in its emit step; the next item is
// taken while the result waits in the output register.
// ============================================================================

module char_lcd_command_sequencer_top #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  lcs_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output lcs_pkg::rsp_t               rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);

    lcs_pkg::ctrl_t               ctrl;
    logic                         req_accept;
    logic                         rsp_free;
    logic                         cfg_write;
    logic                         is_tick;
    logic                         reject;
    logic                         write_go;
    logic                         copy_more;
    logic [lcs_pkg::UPC_W-1:0]    dispatch;
    logic [63:0]                  prod;
    logic [31:0]                  q_times_10;
    logic [31:0]                  remainder;
    logic [CW-1:0]                load_inc;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [7:0]                   ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [7:0]                   ram_rdata;

    logic [lcs_pkg::UPC_W-1:0]    upc_reg, upc_next;
    lcs_pkg::req_t                item_reg, item_next;
    lcs_pkg::status_t             status_reg, status_next;
    logic [7:0]                   power_up_wait_reg, power_up_wait_next;
    lcs_pkg::init_phase_t         init_phase_reg, init_phase_next;
    logic [7:0]                   init_ticks_reg, init_ticks_next;
    logic                         init_complete_reg, init_complete_next;
    lcs_pkg::proc_t               process_reg, process_next;
    logic                         strobe_reg, strobe_next;
    logic [CW-1:0]                load_count_reg, load_count_next;
    logic [CW-1:0]                write_length_reg, write_length_next;
    logic [CW-1:0]                write_index_reg, write_index_next;
    logic [7:0]                   ddram_reg, ddram_next;
    logic [7:0]                   cursor_cmd_reg, cursor_cmd_next;
    logic                         pin_rs_reg, pin_rs_next;
    logic [7:0]                   pin_data_reg, pin_data_next;
    logic [31:0]                  num_reg, num_next;
    logic [lcs_pkg::Q_W-1:0]      q_reg, q_next;
    logic [3:0]                   dig_reg [lcs_pkg::DIGITS];
    logic [3:0]                   dig_next [lcs_pkg::DIGITS];
    logic [3:0]                   dig_cnt_reg, dig_cnt_next;
    logic [3:0]                   copy_idx_reg, copy_idx_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    lcs_pkg::rsp_t                rsp_reg, rsp_next;

    lcs_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ctrl       = lcs_pkg::lcs_ucode(upc_reg);
    assign req_stall  = (upc_reg != lcs_pkg::UPC_FETCH);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2:2] == lcs_pkg::REG_POWER_UP_WAIT)
                        ? {24'b0, power_up_wait_reg} : 32'b0;

    assign is_tick  = (item_reg.opcode == lcs_pkg::OP_TICK);
    assign reject   = !is_tick && ((process_reg != lcs_pkg::PR_IDLE)
                      || (item_reg.opcode > lcs_pkg::OP_PRINT_NUMBER));
    assign write_go = init_complete_reg && (process_reg == lcs_pkg::PR_WRITE)
                      && !strobe_reg && (write_index_reg < write_length_reg)
                      && (write_index_reg < CW'(BUF_DEPTH));

    assign prod       = num_reg * lcs_pkg::RECIP_10;
    assign q_times_10 = 32'({q_reg, 3'b000}) + 32'({q_reg, 1'b0});
    assign remainder  = num_reg - q_times_10;
    assign copy_more  = ((copy_idx_reg + 4'd1) != dig_cnt_reg);
    assign ram_raddr  = write_index_reg[AW-1:0];

    always_comb
    begin
        if (is_tick && write_go)
        begin
            dispatch = lcs_pkg::UPC_READ;
        end
        else if (!is_tick && !reject
                 && (item_reg.opcode == lcs_pkg::OP_PRINT_NUMBER))
        begin
            dispatch = lcs_pkg::UPC_NUM_INIT;
        end
        else
        begin
            dispatch = lcs_pkg::UPC_EXEC;
        end
    end

    always_comb
    begin
        case (ctrl.jmp)
            lcs_pkg::J_ALWAYS:   upc_next = ctrl.target;
            lcs_pkg::J_ACCEPT:   upc_next = req_accept ? ctrl.target : upc_reg;
            lcs_pkg::J_DECODE:   upc_next = dispatch;
            lcs_pkg::J_QNZ:      upc_next = (q_reg != '0) ? ctrl.target : upc_reg + 4'd1;
            lcs_pkg::J_MORE:     upc_next = copy_more ? ctrl.target : upc_reg + 4'd1;
            lcs_pkg::J_OUT_FREE: upc_next = rsp_free ? ctrl.target : upc_reg;
            default:             upc_next = lcs_pkg::UPC_FETCH;
        endcase
    end

    always_comb
    begin
        item_next          = item_reg;
        status_next        = status_reg;
        power_up_wait_next = power_up_wait_reg;
        init_phase_next    = init_phase_reg;
        init_ticks_next    = init_ticks_reg;
        init_complete_next = init_complete_reg;
        process_next       = process_reg;
        strobe_next        = strobe_reg;
        load_count_next    = load_count_reg;
        write_length_next  = write_length_reg;
        write_index_next   = write_index_reg;
        ddram_next         = ddram_reg;
        cursor_cmd_next    = cursor_cmd_reg;
        pin_rs_next        = pin_rs_reg;
        pin_data_next      = pin_data_reg;
        num_next           = num_reg;
        q_next             = q_reg;
        dig_next           = dig_reg;
        dig_cnt_next       = dig_cnt_reg;
        copy_idx_next      = copy_idx_reg;
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        load_inc           = load_count_reg;
        ram_we             = 1'b0;
        ram_waddr          = '0;
        ram_wdata          = '0;

        if (cfg_write && (paddr[2:2] == lcs_pkg::REG_POWER_UP_WAIT))
        begin
            power_up_wait_next = pwdata[7:0];
        end

        case (ctrl.uop)
            lcs_pkg::U_LATCH:
            begin
                if (req_accept)
                begin
                    item_next = req;
                end
            end
            lcs_pkg::U_STATUS:
            begin
                if (is_tick)
                begin
                    status_next = lcs_pkg::ST_TICK;
                end
                else if (reject)
                begin
                    status_next = lcs_pkg::ST_BUSY;
                end
                else
                begin
                    status_next = lcs_pkg::ST_ACCEPTED;
                end
            end
            lcs_pkg::U_EXEC:
            begin
                if (status_reg == lcs_pkg::ST_TICK && !init_complete_reg)
                begin
                    case (init_phase_reg)
                        lcs_pkg::PH_WAIT:
                        begin
                            if (init_ticks_reg == power_up_wait_reg)
                            begin
                                init_phase_next = lcs_pkg::PH_FUNC;
                                init_ticks_next = 8'd0;
                            end
                            else
                            begin
                                init_ticks_next = init_ticks_reg + 8'd1;
                            end
                        end
                        lcs_pkg::PH_FUNC:
                        begin
                            if (!strobe_reg)
                            begin
                                pin_rs_next   = 1'b0;
                                pin_data_next = lcs_pkg::CMD_FUNCTION_SET;
                                strobe_next   = 1'b1;
                            end
                            else
                            begin
                                strobe_next     = 1'b0;
                                init_phase_next = lcs_pkg::PH_DISP;
                            end
                        end
                        lcs_pkg::PH_DISP:
                        begin
                            if (!strobe_reg)
                            begin
                                pin_rs_next   = 1'b0;
                                pin_data_next = lcs_pkg::CMD_DISPLAY_ON;
                                strobe_next   = 1'b1;
                            end
                            else
                            begin
                                strobe_next     = 1'b0;
                                init_phase_next = lcs_pkg::PH_CLR;
                            end
                        end
                        lcs_pkg::PH_CLR:
                        begin
                            if (!strobe_reg)
                            begin
                                pin_rs_next   = 1'b0;
                                pin_data_next = lcs_pkg::CMD_CLEAR;
                                strobe_next   = 1'b1;
                            end
                            else
                            begin
                                strobe_next     = 1'b0;
                                init_phase_next = lcs_pkg::PH_FINISH;
                            end
                        end
                        default:
                        begin
                            init_complete_next = 1'b1;
                        end
                    endcase
                end
                else if (status_reg == lcs_pkg::ST_TICK)
                begin
                    case (process_reg)
                        lcs_pkg::PR_WRITE:
                        begin
                            if (strobe_reg)
                            begin
                                strobe_next = 1'b0;
                            end
                            else
                            begin
                                write_index_next = '0;
                                process_next     = lcs_pkg::PR_IDLE;
                            end
                        end
                        lcs_pkg::PR_CLEAR:
                        begin
                            if (strobe_reg)
                            begin
                                strobe_next  = 1'b0;
                                process_next = lcs_pkg::PR_IDLE;
                            end
                            else
                            begin
                                pin_rs_next   = 1'b0;
                                pin_data_next = lcs_pkg::CMD_CLEAR;
                                strobe_next   = 1'b1;
                            end
                        end
                        lcs_pkg::PR_MOVE:
                        begin
                            if (strobe_reg)
                            begin
                                strobe_next  = 1'b0;
                                process_next = lcs_pkg::PR_IDLE;
                            end
                            else
                            begin
                                pin_rs_next   = 1'b0;
                                pin_data_next = ddram_reg | lcs_pkg::CMD_SET_DDRAM;
                                strobe_next   = 1'b1;
                            end
                        end
                        lcs_pkg::PR_CURSOR:
                        begin
                            if (strobe_reg)
                            begin
                                strobe_next  = 1'b0;
                                process_next = lcs_pkg::PR_IDLE;
                            end
                            else
                            begin
                                pin_rs_next     = 1'b0;
                                pin_data_next   = cursor_cmd_reg;
                                strobe_next     = 1'b1;
                                cursor_cmd_next = 8'd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (status_reg == lcs_pkg::ST_ACCEPTED)
                begin
                    case (item_reg.opcode)
                        lcs_pkg::OP_LOAD_CHAR:
                        begin
                            if (load_count_reg < CW'(BUF_DEPTH))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = load_count_reg[AW-1:0];
                                ram_wdata = item_reg.char_code;
                                load_inc  = load_count_reg + 1'b1;
                            end
                            load_count_next = load_inc;
                            if (item_reg.last_char)
                            begin
                                write_length_next = load_inc;
                                write_index_next  = '0;
                                load_count_next   = '0;
                                process_next      = lcs_pkg::PR_WRITE;
                            end
                        end
                        lcs_pkg::OP_CLEAR:
                        begin
                            process_next = lcs_pkg::PR_CLEAR;
                        end
                        lcs_pkg::OP_GOTO_XY:
                        begin
                            if (item_reg.line_select == lcs_pkg::LINE_ONE)
                            begin
                                ddram_next = {2'b00, item_reg.x_pos};
                            end
                            else if (item_reg.line_select == lcs_pkg::LINE_TWO)
                            begin
                                ddram_next = {2'b00, item_reg.x_pos}
                                             + lcs_pkg::LINE_TWO_OFFSET;
                            end
                            process_next = lcs_pkg::PR_MOVE;
                        end
                        lcs_pkg::OP_SET_CURSOR:
                        begin
                            cursor_cmd_next = lcs_pkg::CMD_DISPLAY_ON
                                | {6'b0, item_reg.cursor_on, item_reg.blink_on};
                            process_next = lcs_pkg::PR_CURSOR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lcs_pkg::U_WR_CHAR:
            begin
                pin_rs_next      = 1'b1;
                pin_data_next    = ram_rdata;
                write_index_next = write_index_reg + 1'b1;
                strobe_next      = 1'b1;
            end
            lcs_pkg::U_NUM_INIT:
            begin
                num_next      = item_reg.number;
                dig_cnt_next  = 4'd0;
                copy_idx_next = 4'd0;
            end
            lcs_pkg::U_MUL:
            begin
                q_next = prod[63:lcs_pkg::Q_SHIFT];
            end
            lcs_pkg::U_DIGIT:
            begin
                dig_next[0] = remainder[3:0];
                for (int i = 1; i < lcs_pkg::DIGITS; i++)
                begin
                    dig_next[i] = dig_reg[i-1];
                end
                dig_cnt_next = dig_cnt_reg + 4'd1;
                num_next     = 32'(q_reg);
            end
            lcs_pkg::U_COPY:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(copy_idx_reg);
                ram_wdata = lcs_pkg::ASCII_ZERO + {4'b0000, dig_reg[0]};
                for (int i = 0; i < lcs_pkg::DIGITS - 1; i++)
                begin
                    dig_next[i] = dig_reg[i+1];
                end
                dig_next[lcs_pkg::DIGITS-1] = 4'd0;
                copy_idx_next = copy_idx_reg + 4'd1;
            end
            lcs_pkg::U_NUM_DONE:
            begin
                write_length_next = CW'(dig_cnt_reg);
                write_index_next  = '0;
                load_count_next   = '0;
                process_next      = lcs_pkg::PR_WRITE;
            end
            lcs_pkg::U_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = status_reg;
                    rsp_next.lcd_rs    = pin_rs_reg;
                    rsp_next.lcd_rw    = 1'b0;
                    rsp_next.lcd_en    = strobe_reg;
                    rsp_next.lcd_data  = pin_data_reg;
                    rsp_next.init_done = init_complete_reg;
                    rsp_next.idle      = (process_reg == lcs_pkg::PR_IDLE);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg           <= lcs_pkg::UPC_FETCH;
            power_up_wait_reg <= lcs_pkg::POWER_UP_WAIT_RESET;
            init_phase_reg    <= lcs_pkg::PH_WAIT;
            init_ticks_reg    <= 8'd0;
            init_complete_reg <= 1'b0;
            process_reg       <= lcs_pkg::PR_IDLE;
            strobe_reg        <= 1'b0;
            load_count_reg    <= '0;
            write_length_reg  <= '0;
            write_index_reg   <= '0;
            ddram_reg         <= 8'd0;
            cursor_cmd_reg    <= 8'd0;
            pin_rs_reg        <= 1'b0;
            pin_data_reg      <= 8'd0;
            dig_cnt_reg       <= 4'd0;
            copy_idx_reg      <= 4'd0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            upc_reg           <= upc_next;
            power_up_wait_reg <= power_up_wait_next;
            init_phase_reg    <= init_phase_next;
            init_ticks_reg    <= init_ticks_next;
            init_complete_reg <= init_complete_next;
            process_reg       <= process_next;
            strobe_reg        <= strobe_next;
            load_count_reg    <= load_count_next;
            write_length_reg  <= write_length_next;
            write_index_reg   <= write_index_next;
            ddram_reg         <= ddram_next;
            cursor_cmd_reg    <= cursor_cmd_next;
            pin_rs_reg        <= pin_rs_next;
            pin_data_reg      <= pin_data_next;
            dig_cnt_reg       <= dig_cnt_next;
            copy_idx_reg      <= copy_idx_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        num_reg    <= num_next;
        q_reg      <= q_next;
        dig_reg    <= dig_next;
        rsp_reg    <= rsp_next;
    end

`ifndef SYNTHESIS
    a_load_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CW'(BUF_DEPTH))
        else $error("Character load count exceeds the buffer depth.");

    a_index_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        write_index_reg <= write_length_reg)
        else $error("Write index ran past the write length.");

    a_cursor_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (process_reg != lcs_pkg::PR_CURSOR) |-> (cursor_cmd_reg == 8'd0))
        else $error("Cursor command pending outside the cursor process.");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (init_complete_reg && process_reg == lcs_pkg::PR_IDLE) |-> !strobe_reg)
        else $error("Enable left high with no process running.");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (upc_reg == lcs_pkg::UPC_DECODE))
        else $error("Accepted item did not move the sequencer to decode.");
`endif

endmodule

>>> hdl/lcs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lcs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
